FILE: hdl/hbst_pkg.sv
// hbst_pkg: shared types and codes for the hash bucket slot table
// result beat layout, operation and status codes, result limit
// no dependencies
`default_nettype none

package hbst_pkg;

    localparam int MAX_RESULTS = 32;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    localparam logic [2:0] OP_LOOKUP      = 3'd0;
    localparam logic [2:0] OP_INSERT      = 3'd1;
    localparam logic [2:0] OP_REMOVE_PAIR = 3'd2;
    localparam logic [2:0] OP_REMOVE_SLOT = 3'd3;
    localparam logic [2:0] OP_READ_SLOT   = 3'd4;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_DUPLICATE = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] out_key;
        logic [31:0] out_value;
        logic        last;
        logic [5:0]  live_count;
        logic        is_full;
        logic        is_empty;
    } res_t;

endpackage

`default_nettype wire

FILE: hdl/hbst_slot_ram.sv
// hbst_slot_ram: slot storage, one write port and one registered read port
// used for both the key and the value columns
// no package dependencies
`default_nettype none

module hbst_slot_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 32
) (
    input  wire logic                             clk,
    input  wire logic                             we,
    input  wire logic [$clog2(DEPTH)-1:0]         waddr,
    input  wire logic [WIDTH-1:0]                 wdata,
    input  wire logic                             re,
    input  wire logic [$clog2(DEPTH)-1:0]         raddr,
    output logic      [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: hdl/hbst_out_reg.sv
// hbst_out_reg: output register between the sequencer and the result channel
// uses hbst_pkg for the result beat type
`default_nettype none

module hbst_out_reg (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          load_valid,
    output logic               load_ready,
    input  wire hbst_pkg::res_t load_res,
    output logic               out_valid,
    input  wire logic          out_stall,
    output hbst_pkg::res_t     out_res
);

    import hbst_pkg::*;

    logic vld_reg;
    res_t res_reg;

    assign load_ready = !vld_reg || !out_stall;
    assign out_valid  = vld_reg;
    assign out_res    = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (load_ready)
        begin
            vld_reg <= load_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_ready && load_valid)
        begin
            res_reg <= load_res;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/hbst_seq.sv
// hbst_seq: scan sequencer with the shared slot compare unit and slot marks
// walks slots one a cycle via slot rams unless a beat waits, builds beats
// uses hbst_pkg for codes and the result beat type
`default_nettype none

module hbst_seq #(
    parameter int SLOTS       = 32,
    parameter int KEY_WIDTH   = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [2:0]                   operation,
    input  wire logic [31:0]                  key,
    input  wire logic [31:0]                  value,
    input  wire logic [4:0]                   slot,
    output logic                              ram_re,
    output logic [$clog2(SLOTS)-1:0]          ram_raddr,
    output logic                              ram_we,
    output logic [$clog2(SLOTS)-1:0]          ram_waddr,
    output logic [KEY_WIDTH-1:0]              ram_wkey,
    output logic [VALUE_WIDTH-1:0]            ram_wval,
    input  wire logic [KEY_WIDTH-1:0]         ram_rkey,
    input  wire logic [VALUE_WIDTH-1:0]       ram_rval,
    output logic                              emit_valid,
    input  wire logic                         emit_ready,
    output hbst_pkg::res_t                    emit_res
);

    import hbst_pkg::*;

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CW    = $clog2(SLOTS + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t                 state_reg, state_next;
    logic [2:0]             op_reg;
    logic [KEY_WIDTH-1:0]   key_reg;
    logic [VALUE_WIDTH-1:0] val_reg;
    logic [4:0]             slot_reg;
    logic [IDX_W-1:0]       idx_reg;
    logic [IDX_W-1:0]       pos_reg;
    logic                   hit_reg;
    logic                   dup_reg;
    logic                   pend_vld_reg;
    logic [VALUE_WIDTH-1:0] pend_val_reg;
    logic [CNT_W-1:0]       mcnt_reg;
    logic [SLOTS-1:0]       live_reg, live_next;
    logic [SLOTS-1:0]       occ_reg, occ_next;
    logic [CW-1:0]          cnt_reg, cnt_next;

    logic [63:0]            key_wide, val_wide, okey_wide, oval_wide, pend_wide;
    logic [6:0]             in_slot_ext, slot_ext;
    logic                   slot_ok, slot_live;
    logic [IDX_W-1:0]       slot_idx;
    logic                   accept;

    logic                   cur_live, cur_occ, keq, veq, pair_eq;
    logic                   last_idx, match, end_scan, hold, done_fire;
    logic [CNT_W-1:0]       mcnt_inc;
    logic                   op_ok;
    status_t                done_status;
    logic [CW-1:0]          cnt_out;
    logic [63:0]            cnt_wide;

    assign key_wide    = {32'd0, key};
    assign val_wide    = {32'd0, value};
    assign in_slot_ext = {2'b00, slot};
    assign slot_ext    = {2'b00, slot_reg};
    assign slot_ok     = slot_ext < 7'(SLOTS);
    assign slot_idx    = slot_ext[IDX_W-1:0];
    assign slot_live   = slot_ok && live_reg[slot_idx];

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && (state_reg == S_IDLE);

    // shared slot compare unit
    assign cur_live = live_reg[idx_reg];
    assign cur_occ  = occ_reg[idx_reg];
    assign keq      = (ram_rkey == key_reg);
    assign veq      = (ram_rval == val_reg);
    assign pair_eq  = cur_live && keq && veq;
    assign last_idx = (idx_reg == IDX_W'(SLOTS - 1));
    assign mcnt_inc = mcnt_reg + CNT_W'(1);
    assign match    = cur_live && keq;

    always_comb
    begin
        end_scan = last_idx;
        case (op_reg)
            OP_LOOKUP:
            begin
                end_scan = last_idx || (!cur_live && !cur_occ)
                           || (match && (mcnt_inc == CNT_W'(MAX_RESULTS)));
            end
            OP_INSERT:
            begin
                end_scan = last_idx || pair_eq || (!cur_live && !cur_occ);
            end
            OP_REMOVE_PAIR:
            begin
                end_scan = last_idx || pair_eq || !cur_occ;
            end
            default:
            begin
                end_scan = 1'b1;
            end
        endcase
    end

    // a lookup match pushes out the match held before it
    assign hold = (state_reg == S_SCAN) && (op_reg == OP_LOOKUP) && match
                  && pend_vld_reg && !emit_ready;
    assign done_fire = (state_reg == S_DONE) && emit_ready;

    always_comb
    begin
        op_ok       = 1'b0;
        done_status = ST_NOT_FOUND;
        case (op_reg)
            OP_LOOKUP:
            begin
                op_ok       = pend_vld_reg;
                done_status = pend_vld_reg ? ST_OK : ST_NOT_FOUND;
            end
            OP_INSERT:
            begin
                op_ok       = !dup_reg && hit_reg;
                done_status = dup_reg ? ST_DUPLICATE : (hit_reg ? ST_OK : ST_FULL);
            end
            OP_REMOVE_PAIR:
            begin
                op_ok       = hit_reg;
                done_status = hit_reg ? ST_OK : ST_NOT_FOUND;
            end
            OP_REMOVE_SLOT, OP_READ_SLOT:
            begin
                op_ok       = slot_live;
                done_status = slot_live ? ST_OK : ST_NOT_FOUND;
            end
            default:
            begin
                op_ok       = 1'b0;
                done_status = ST_NOT_FOUND;
            end
        endcase
    end

    always_comb
    begin
        live_next = live_reg;
        occ_next  = occ_reg;
        cnt_next  = cnt_reg;
        if (done_fire && op_ok)
        begin
            case (op_reg)
                OP_INSERT:
                begin
                    live_next = live_reg | (SLOTS'(1) << pos_reg);
                    occ_next  = occ_reg | (SLOTS'(1) << pos_reg);
                    cnt_next  = cnt_reg + CW'(1);
                end
                OP_REMOVE_PAIR:
                begin
                    live_next = live_reg & ~(SLOTS'(1) << pos_reg);
                    cnt_next  = cnt_reg - CW'(1);
                end
                OP_REMOVE_SLOT:
                begin
                    live_next = live_reg & ~(SLOTS'(1) << slot_idx);
                    cnt_next  = cnt_reg - CW'(1);
                end
                default:
                begin
                    live_next = live_reg;
                end
            endcase
        end
    end

    assign ram_we    = done_fire && op_ok && (op_reg == OP_INSERT);
    assign ram_waddr = pos_reg;
    assign ram_wkey  = key_reg;
    assign ram_wval  = val_reg;

    always_comb
    begin
        ram_re    = 1'b0;
        ram_raddr = '0;
        if (accept)
        begin
            ram_re    = 1'b1;
            ram_raddr = (operation == OP_READ_SLOT) ? in_slot_ext[IDX_W-1:0] : '0;
        end
        else if ((state_reg == S_SCAN) && !hold && !end_scan)
        begin
            ram_re    = 1'b1;
            ram_raddr = idx_reg + IDX_W'(1);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if ((operation == OP_LOOKUP) || (operation == OP_INSERT)
                        || (operation == OP_REMOVE_PAIR))
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_SCAN:
            begin
                if (!hold && end_scan)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (emit_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            live_reg     <= '0;
            occ_reg      <= '0;
            cnt_reg      <= '0;
            hit_reg      <= 1'b0;
            dup_reg      <= 1'b0;
            pend_vld_reg <= 1'b0;
            mcnt_reg     <= '0;
            idx_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            live_reg  <= live_next;
            occ_reg   <= occ_next;
            cnt_reg   <= cnt_next;
            if (accept)
            begin
                hit_reg      <= 1'b0;
                dup_reg      <= 1'b0;
                pend_vld_reg <= 1'b0;
                mcnt_reg     <= '0;
                idx_reg      <= '0;
            end
            else if ((state_reg == S_SCAN) && !hold)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
                case (op_reg)
                    OP_LOOKUP:
                    begin
                        if (match)
                        begin
                            pend_vld_reg <= 1'b1;
                            mcnt_reg     <= mcnt_inc;
                        end
                    end
                    OP_INSERT:
                    begin
                        if (pair_eq)
                        begin
                            dup_reg <= 1'b1;
                        end
                        if (!cur_live && !hit_reg)
                        begin
                            hit_reg <= 1'b1;
                        end
                    end
                    OP_REMOVE_PAIR:
                    begin
                        if (pair_eq)
                        begin
                            hit_reg <= 1'b1;
                        end
                    end
                    default:
                    begin
                        hit_reg <= hit_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= operation;
            key_reg  <= key_wide[KEY_WIDTH-1:0];
            val_reg  <= val_wide[VALUE_WIDTH-1:0];
            slot_reg <= slot;
        end
        else if ((state_reg == S_SCAN) && !hold)
        begin
            if ((op_reg == OP_LOOKUP) && match)
            begin
                pend_val_reg <= ram_rval;
            end
            if ((op_reg == OP_INSERT) && !cur_live && !hit_reg)
            begin
                pos_reg <= idx_reg;
            end
            if ((op_reg == OP_REMOVE_PAIR) && pair_eq)
            begin
                pos_reg <= idx_reg;
            end
        end
    end

    // result beat
    always_comb
    begin
        okey_wide = '0;
        oval_wide = '0;
        pend_wide = '0;
        okey_wide[KEY_WIDTH-1:0]   = ram_rkey;
        oval_wide[VALUE_WIDTH-1:0] = ram_rval;
        pend_wide[VALUE_WIDTH-1:0] = pend_val_reg;
    end

    assign cnt_out  = (state_reg == S_DONE) ? cnt_next : cnt_reg;
    assign cnt_wide = 64'(cnt_out);

    always_comb
    begin
        emit_valid          = 1'b0;
        emit_res.status     = ST_OK;
        emit_res.out_key    = '0;
        emit_res.out_value  = '0;
        emit_res.last       = 1'b0;
        emit_res.live_count = cnt_wide[5:0];
        emit_res.is_full    = (cnt_out == CW'(SLOTS));
        emit_res.is_empty   = (cnt_out == '0);
        if (state_reg == S_DONE)
        begin
            emit_valid      = 1'b1;
            emit_res.status = done_status;
            emit_res.last   = 1'b1;
            if ((op_reg == OP_LOOKUP) && pend_vld_reg)
            begin
                emit_res.out_value = pend_wide[31:0];
            end
            else if ((op_reg == OP_READ_SLOT) && slot_live)
            begin
                emit_res.out_key   = okey_wide[31:0];
                emit_res.out_value = oval_wide[31:0];
            end
        end
        else if ((state_reg == S_SCAN) && (op_reg == OP_LOOKUP) && match && pend_vld_reg)
        begin
            emit_valid         = 1'b1;
            emit_res.out_value = pend_wide[31:0];
        end
    end

endmodule

`default_nettype wire

FILE: hdl/hash_bucket_slot_table.sv
// hash_bucket_slot_table: one bucket of key/value slots with occupied and live marks
// lookup, insert and remove scan at one slot a cycle unless a lookup beat waits;
// slot operations skip the scan; the scan length is set by the single read port
// of the slot rams feeding one shared compare unit; a lookup may give many beats
// results leave through an output register, so the next item is taken while one waits
// reset clears the marks and the live count at once; slot rams are not cleared
`default_nettype none

module hash_bucket_slot_table #(
    parameter int SLOTS       = 32,
    parameter int KEY_WIDTH   = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  operation,
    input  wire logic [31:0] key,
    input  wire logic [31:0] value,
    input  wire logic [4:0]  slot,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       status,
    output logic [31:0]      out_key,
    output logic [31:0]      out_value,
    output logic             last,
    output logic [5:0]       live_count,
    output logic             is_full,
    output logic             is_empty
);

    import hbst_pkg::*;

    localparam int IDX_W = $clog2(SLOTS);

    logic                   ram_re, ram_we;
    logic [IDX_W-1:0]       ram_raddr, ram_waddr;
    logic [KEY_WIDTH-1:0]   ram_wkey, ram_rkey;
    logic [VALUE_WIDTH-1:0] ram_wval, ram_rval;
    logic                   emit_valid, emit_ready;
    res_t                   emit_res, out_res;

    hbst_slot_ram #(
        .DEPTH (SLOTS),
        .WIDTH (KEY_WIDTH)
    ) u_key_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wkey),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rkey)
    );

    hbst_slot_ram #(
        .DEPTH (SLOTS),
        .WIDTH (VALUE_WIDTH)
    ) u_val_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wval),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rval)
    );

    hbst_seq #(
        .SLOTS       (SLOTS),
        .KEY_WIDTH   (KEY_WIDTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .operation  (operation),
        .key        (key),
        .value      (value),
        .slot       (slot),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wkey   (ram_wkey),
        .ram_wval   (ram_wval),
        .ram_rkey   (ram_rkey),
        .ram_rval   (ram_rval),
        .emit_valid (emit_valid),
        .emit_ready (emit_ready),
        .emit_res   (emit_res)
    );

    hbst_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (emit_valid),
        .load_ready (emit_ready),
        .load_res   (emit_res),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_res    (out_res)
    );

    assign status     = out_res.status;
    assign out_key    = out_res.out_key;
    assign out_value  = out_res.out_value;
    assign last       = out_res.last;
    assign live_count = out_res.live_count;
    assign is_full    = out_res.is_full;
    assign is_empty   = out_res.is_empty;

endmodule

`default_nettype wire
